// ===== rtl/nnis_pkg.sv =====
// ============================================================================
// nnis_pkg
// Shared types, widths and codes for the nearest-neighbor image scaler.
// ============================================================================
package nnis_pkg;

   // Defaults for the top-level size parameters.
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int DEF_MAX_FACTOR = 16;

   // Field widths fixed by the register map.
   localparam int DIM_W  = 7;               // source width / height
   localparam int FAC_W  = 5;               // shrink / grow
   localparam int PIX_W  = 24;              // one RGB pixel
   localparam int CHAN_W = 8;               // one color component
   localparam int OUT_W  = DIM_W + FAC_W;   // output width / height and position
   localparam int PROD_W = OUT_W + FAC_W;   // position times shrink
   localparam int AREA_W = 2 * DIM_W;       // source pixel count
   localparam int Q_W    = DIM_W;           // quotient bits of every division

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_SHRINK     = 2'd2,
      REG_GROW       = 2'd3
   } reg_idx_type;

   // Operation carried in the request user field.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Register file contents.
   typedef struct packed {
      logic [DIM_W-1:0] src_width;
      logic [DIM_W-1:0] src_height;
      logic [FAC_W-1:0] shrink;
      logic [FAC_W-1:0] grow;
   } cfg_type;

   // Divider request and response.
   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [FAC_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/nearest_neighbor_image_scaler_top.sv =====
// ============================================================================
// nearest_neighbor_image_scaler_top
// Nearest-neighbor RGB scaler by grow/shrink over a frame store.
//
// Load beats (tuser 0) fill the frame store in raster order; beats beyond the
// source frame are dropped. Read beats (tuser 1) each return the next output
// pixel in raster order, with row_end on tlast and frame_end / none_left on
// tuser. The output is (width/shrink)*grow by (height/shrink)*grow pixels.
// The block takes one beat at a time. A load, and a read of an exhausted or
// empty output, skip the divider. A pixel read makes two passes through the
// shared one-bit-per-cycle divider (source row, then source column). The
// first beat after a register write first computes the output size. A
// finished result waits in an output register while the next beat is
// taken. The frame store is not cleared; only reset starts a new frame.
// ============================================================================
module nearest_neighbor_image_scaler_top
   import nnis_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // in_blue, in_green, in_red
   input  logic                  req_tuser,   // operation
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,   // out_blue, out_green, out_red
   output logic                  rsp_tlast,   // row_end
   output logic [1:0]            rsp_tuser,   // frame_end, none_left
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LCNT_W = $clog2(DEPTH + 1);
   localparam int MUL_W  = OUT_W + DIM_W;

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_G_DW   = 16'h0002,
      ST_G_WW   = 16'h0004,
      ST_G_DH   = 16'h0008,
      ST_G_WH   = 16'h0010,
      ST_G_MUL  = 16'h0020,
      ST_LOAD   = 16'h0040,
      ST_CHECK  = 16'h0080,
      ST_R_DIV  = 16'h0100,
      ST_R_WAIT = 16'h0200,
      ST_C_MUL  = 16'h0400,
      ST_C_DIV  = 16'h0800,
      ST_C_WAIT = 16'h1000,
      ST_A_MUL  = 16'h2000,
      ST_A_ADD  = 16'h4000,
      ST_EMIT   = 16'h8000
   } state_type;

   state_type         state_ff;
   cfg_type           cfg;
   logic              cfg_wr;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic              dirty_ff;
   logic              op_ff;
   logic [PIX_W-1:0]  pix_ff;
   logic [LCNT_W-1:0] load_count_ff;
   logic [OUT_W-1:0]  out_row_ff;
   logic [OUT_W-1:0]  out_col_ff;
   logic              done_ff;
   logic              none_ff;
   logic [DIM_W-1:0]  qw_ff;
   logic [DIM_W-1:0]  qh_ff;
   logic [OUT_W-1:0]  ow_ff;
   logic [OUT_W-1:0]  oh_ff;
   logic [AREA_W-1:0] area_ff;
   logic [DIM_W-1:0]  srow_ff;
   logic [DIM_W-1:0]  scol_ff;
   logic [PROD_W-1:0] prod_ff;

   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  rsp_data_ff;
   logic              rsp_last_ff;
   logic [1:0]        rsp_user_ff;

   logic [DIM_W-1:0]  eff_w;
   logic [DIM_W-1:0]  eff_h;
   logic [FAC_W-1:0]  eff_s;
   logic [FAC_W-1:0]  eff_g;
   logic [OUT_W-1:0]  mul_a;
   logic [DIM_W-1:0]  mul_b;
   logic [MUL_W-1:0]  mul_p;
   logic [PROD_W:0]   addr_sum;
   logic [PIX_W-1:0]  ram_rd_data;
   logic              in_accept;
   logic              slot_free;
   logic              in_frame;
   logic              is_none;
   logic              rend;
   logic              fend;

   // Configuration registers.
   nnis_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_wr      (cfg_wr)
   );

   // Effective geometry after clamping.
   assign eff_w = (int'(cfg.src_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg.src_width;
   assign eff_h = (int'(cfg.src_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg.src_height;
   assign eff_s = (cfg.shrink == '0) ? FAC_W'(1) :
                  (int'(cfg.shrink) > MAX_FACTOR) ? FAC_W'(MAX_FACTOR) : cfg.shrink;
   assign eff_g = (int'(cfg.grow) > MAX_FACTOR) ? FAC_W'(MAX_FACTOR) : cfg.grow;

   // Handshake helpers.
   assign req_tready = (state_ff == ST_IDLE);
   assign in_accept  = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign in_frame   = (32'(load_count_ff) < 32'(area_ff));

   // Read condition and end-of-row / end-of-frame marks.
   assign is_none = done_ff || (ow_ff == '0) || (oh_ff == '0) ||
                    (out_row_ff >= oh_ff) || (out_col_ff >= ow_ff);
   assign rend    = (out_col_ff == ow_ff - OUT_W'(1));
   assign fend    = rend && (out_row_ff == oh_ff - OUT_W'(1));

   // Divider operands by sequencer step.
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = eff_g;
      unique case (state_ff)
         ST_G_DW: begin
            div_req.start    = 1'b1;
            div_req.dividend = PROD_W'(eff_w);
            div_req.divisor  = eff_s;
         end
         ST_G_DH: begin
            div_req.start    = 1'b1;
            div_req.dividend = PROD_W'(eff_h);
            div_req.divisor  = eff_s;
         end
         ST_R_DIV, ST_C_DIV: begin
            div_req.start = 1'b1;
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   nnis_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Multiplier operands: position times shrink, or source row times width.
   always_comb begin
      mul_a = out_row_ff;
      mul_b = DIM_W'(eff_s);
      unique case (state_ff)
         ST_C_MUL: begin
            mul_a = out_col_ff;
         end
         ST_A_MUL: begin
            mul_a = OUT_W'(srow_ff);
            mul_b = eff_w;
         end
         default: begin
            mul_a = out_row_ff;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign addr_sum = {1'b0, prod_ff} + (PROD_W + 1)'(scol_ff);

   // Frame store.
   nnis_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   ((state_ff == ST_LOAD) && in_frame),
      .wr_addr (load_count_ff[ADDR_W-1:0]),
      .wr_data (pix_ff),
      .rd_en   (state_ff == ST_A_ADD),
      .rd_addr (ADDR_W'(addr_sum)),
      .rd_data (ram_rd_data)
   );

   // Sequencer and its control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dirty_ff      <= 1'b1;
         load_count_ff <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         done_ff       <= 1'b0;
         none_ff       <= 1'b0;
      end else begin
         if (cfg_wr) begin
            dirty_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (in_accept) begin
                  if (dirty_ff) begin
                     state_ff <= ST_G_DW;
                  end else if (req_tuser == OP_READ) begin
                     state_ff <= ST_CHECK;
                  end else begin
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_G_DW: begin
               state_ff <= ST_G_WW;
            end
            ST_G_WW: begin
               if (div_rsp.done) begin
                  state_ff <= ST_G_DH;
               end
            end
            ST_G_DH: begin
               state_ff <= ST_G_WH;
            end
            ST_G_WH: begin
               if (div_rsp.done) begin
                  state_ff <= ST_G_MUL;
               end
            end
            ST_G_MUL: begin
               dirty_ff <= 1'b0;
               state_ff <= (op_ff == OP_READ) ? ST_CHECK : ST_LOAD;
            end
            ST_LOAD: begin
               if (in_frame) begin
                  load_count_ff <= load_count_ff + LCNT_W'(1);
               end
               state_ff <= ST_IDLE;
            end
            ST_CHECK: begin
               none_ff  <= is_none;
               state_ff <= is_none ? ST_EMIT : ST_R_DIV;
            end
            ST_R_DIV: begin
               state_ff <= ST_R_WAIT;
            end
            ST_R_WAIT: begin
               if (div_rsp.done) begin
                  state_ff <= ST_C_MUL;
               end
            end
            ST_C_MUL: begin
               state_ff <= ST_C_DIV;
            end
            ST_C_DIV: begin
               state_ff <= ST_C_WAIT;
            end
            ST_C_WAIT: begin
               if (div_rsp.done) begin
                  state_ff <= ST_A_MUL;
               end
            end
            ST_A_MUL: begin
               state_ff <= ST_A_ADD;
            end
            ST_A_ADD: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
                  if (!none_ff) begin
                     if (fend) begin
                        done_ff    <= 1'b1;
                        out_row_ff <= '0;
                        out_col_ff <= '0;
                     end else if (rend) begin
                        out_col_ff <= '0;
                        out_row_ff <= out_row_ff + OUT_W'(1);
                     end else begin
                        out_col_ff <= out_col_ff + OUT_W'(1);
                     end
                  end
               end
            end
         endcase
      end
   end

   // Datapath registers: beat capture, geometry, quotients and products.
   always_ff @(posedge clock) begin
      if (in_accept) begin
         op_ff  <= req_tuser;
         pix_ff <= req_tdata;
      end
      if ((state_ff == ST_G_WW) && div_rsp.done) begin
         qw_ff <= div_rsp.quotient;
      end
      if ((state_ff == ST_G_WH) && div_rsp.done) begin
         qh_ff <= div_rsp.quotient;
      end
      if (state_ff == ST_G_MUL) begin
         ow_ff   <= qw_ff * eff_g;
         oh_ff   <= qh_ff * eff_g;
         area_ff <= eff_w * eff_h;
      end
      if ((state_ff == ST_R_WAIT) && div_rsp.done) begin
         srow_ff <= div_rsp.quotient;
      end
      if ((state_ff == ST_C_WAIT) && div_rsp.done) begin
         scol_ff <= div_rsp.quotient;
      end
      if ((state_ff == ST_CHECK) || (state_ff == ST_C_MUL) || (state_ff == ST_A_MUL)) begin
         prod_ff <= mul_p[PROD_W-1:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_EMIT) && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_EMIT) && slot_free) begin
         rsp_data_ff <= none_ff ? '0 : ram_rd_data;
         rsp_last_ff <= !none_ff && rend;
         rsp_user_ff <= {none_ff, !none_ff && fend};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/nnis_ram.sv =====
// ============================================================================
// nnis_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module nnis_ram #(
   parameter  int WIDTH  = 24,
   parameter  int DEPTH  = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nnis_div.sv =====
// ============================================================================
// nnis_div
// Shared restoring divider, one quotient bit per cycle.
// ============================================================================
module nnis_div
   import nnis_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(Q_W);

   logic [PROD_W-1:0] rem_ff;
   logic [PROD_W-1:0] dsh_ff;
   logic [Q_W-1:0]    quo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic              fits;

   // The shifted divisor fits into what is left of the dividend.
   assign fits = (rem_ff >= dsh_ff);

   // Control: step count, busy and the done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !div_req.start && (cnt_ff == CNT_W'(Q_W - 1));
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(Q_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath: compare, subtract and shift once per cycle.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= div_req.dividend;
         dsh_ff <= PROD_W'({div_req.divisor, {(Q_W-1){1'b0}}});
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         quo_ff <= {quo_ff[Q_W-2:0], fits};
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/nnis_csr.sv =====
// ============================================================================
// nnis_csr
// Configuration registers behind a simple APB-style port.
// ============================================================================
module nnis_csr
   import nnis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg,
   output logic                  cfg_wr
);

   cfg_type     cfg_ff;
   reg_idx_type idx;

   assign csr_pready = 1'b1;
   assign idx        = reg_idx_type'(csr_paddr[3:2]);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= DIM_W'(64);
         cfg_ff.src_height <= DIM_W'(64);
         cfg_ff.shrink     <= FAC_W'(1);
         cfg_ff.grow       <= FAC_W'(1);
      end else if (cfg_wr) begin
         unique case (idx)
            REG_SRC_WIDTH:  cfg_ff.src_width  <= csr_pwdata[DIM_W-1:0];
            REG_SRC_HEIGHT: cfg_ff.src_height <= csr_pwdata[DIM_W-1:0];
            REG_SHRINK:     cfg_ff.shrink     <= csr_pwdata[FAC_W-1:0];
            REG_GROW:       cfg_ff.grow       <= csr_pwdata[FAC_W-1:0];
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (idx)
         REG_SRC_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.src_width);
         REG_SRC_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.src_height);
         REG_SHRINK:     csr_prdata = CSR_DATA_W'(cfg_ff.shrink);
         REG_GROW:       csr_prdata = CSR_DATA_W'(cfg_ff.grow);
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/nnis_checker.sv =====
// ============================================================================
// nnis_checker
// Port-level checks for the nearest-neighbor image scaler.
// ============================================================================
module nnis_checker
   import nnis_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [PIX_W-1:0] rsp_tdata,
   input logic             rsp_tlast,
   input logic [1:0]       rsp_tuser
);

   // No result beat is offered right after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result beat offered right after reset");

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // The block is not ready again right after it takes a request beat.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on two cycles in a row");

   // An exhausted read carries no pixel and no end marks.
   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata == '0) && !rsp_tlast && !rsp_tuser[0])
      else $error("none_left beat carries data or end marks");

   // The last pixel of the frame is also the last of its row.
   a_frame_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame_end without row_end");

endmodule

bind nearest_neighbor_image_scaler_top nnis_checker u_nnis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/nearest_neighbor_image_scaler_top_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nearest_neighbor_image_scaler_top_test
// Self-checking bench for the nearest-neighbor image scaler.
//
// A shadow copy of the frame store, the load count and the read position
// predicts every output pixel. Load and read beats go in in random bursts
// while the result side stalls on its own pattern. One long hold-off on the
// result side backs the block up. The register settings change between
// phases, extremes included. A closing setting is chosen so that the
// readout reaches the end of the frame.
// ============================================================================
module nearest_neighbor_image_scaler_top_test;
   import nnis_pkg::*;

   localparam int STORE_DEPTH   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam int RANDOM_BEATS  = 1500;
   localparam int CLOSING_CAP   = 3000;
   localparam int SETTLE_CYCLES = 48;    // slowest read plus the size pass after a write
   localparam int HOLD_AFTER    = 300;   // results seen before the long hold-off
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             row_end;
      logic             frame_end;
      logic             none_left;
   } out_pixel_t;

   function automatic int unsigned clip(int unsigned v, int unsigned hi);
      return (v > hi) ? hi : v;
   endfunction

   // A zero shrink acts as one; large factors saturate.
   function automatic int unsigned eff_shrink(int unsigned s);
      return (s == 0) ? 1 : clip(s, DEF_MAX_FACTOR);
   endfunction

   // Output extent along one axis for raw register values.
   function automatic int unsigned out_extent(int unsigned dim, int unsigned cap,
                                              int unsigned s, int unsigned g);
      return (clip(dim, cap) / eff_shrink(s)) * clip(g, DEF_MAX_FACTOR);
   endfunction

   // Shadow of the scaler state, with the queue of pixels still owed.
   class pixel_board;
      cfg_type          cfg;
      logic [PIX_W-1:0] store [STORE_DEPTH];
      int unsigned      loaded;
      int unsigned      row;
      int unsigned      col;
      bit               finished;
      out_pixel_t       pixels_due [$];
      int unsigned      pixels_seen;
      int unsigned      errors;

      function new();
         cfg.src_width  = DIM_W'(DEF_MAX_WIDTH);
         cfg.src_height = DIM_W'(DEF_MAX_HEIGHT);
         cfg.shrink     = FAC_W'(1);
         cfg.grow       = FAC_W'(1);
         loaded      = 0;
         row         = 0;
         col         = 0;
         finished    = 1'b0;
         pixels_seen = 0;
         errors      = 0;
      endfunction

      function void set_reg(reg_idx_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_SRC_WIDTH:  cfg.src_width  = value[DIM_W-1:0];
            REG_SRC_HEIGHT: cfg.src_height = value[DIM_W-1:0];
            REG_SHRINK:     cfg.shrink     = value[FAC_W-1:0];
            REG_GROW:       cfg.grow       = value[FAC_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned out_cols();
         return out_extent(cfg.src_width, DEF_MAX_WIDTH, cfg.shrink, cfg.grow);
      endfunction

      function int unsigned out_rows();
         return out_extent(cfg.src_height, DEF_MAX_HEIGHT, cfg.shrink, cfg.grow);
      endfunction

      // A load lands only while the source frame is not yet full.
      function bit load_takes();
         return loaded < clip(cfg.src_width, DEF_MAX_WIDTH) *
                         clip(cfg.src_height, DEF_MAX_HEIGHT) && loaded < STORE_DEPTH;
      endfunction

      // Store entry the next read copies, or -1 when no pixel remains.
      function int source_index();
         int unsigned s;
         int unsigned g;
         if (finished || out_cols() == 0 || out_rows() == 0 ||
             row >= out_rows() || col >= out_cols())
            return -1;
         s = eff_shrink(cfg.shrink);
         g = clip(cfg.grow, DEF_MAX_FACTOR);
         return (row * s / g) * clip(cfg.src_width, DEF_MAX_WIDTH) + col * s / g;
      endfunction

      // A read must never touch a store entry that has not been loaded.
      function bit read_safe();
         int idx;
         idx = source_index();
         return idx < 0 || idx < int'(loaded);
      endfunction

      // Would the read position lie inside the output of this setting?
      function bit fits(cfg_type c);
         return row < out_extent(c.src_height, DEF_MAX_HEIGHT, c.shrink, c.grow) &&
                col < out_extent(c.src_width, DEF_MAX_WIDTH, c.shrink, c.grow);
      endfunction

      // Apply one accepted beat; a read owes exactly one pixel.
      function void take_beat(logic op, logic [PIX_W-1:0] pix);
         int         idx;
         out_pixel_t px;
         if (op == OP_LOAD) begin
            if (load_takes()) begin
               store[loaded] = pix;
               loaded++;
            end
            return;
         end
         px  = '0;
         idx = source_index();
         if (idx < 0) begin
            px.none_left = 1'b1;
         end else begin
            px.pixel     = (idx < STORE_DEPTH) ? store[idx] : '0;
            px.row_end   = (col == out_cols() - 1);
            px.frame_end = px.row_end && (row == out_rows() - 1);
            if (px.frame_end) begin
               finished = 1'b1;
               row = 0;
               col = 0;
            end else if (px.row_end) begin
               col = 0;
               row++;
            end else begin
               col++;
            end
         end
         pixels_due.push_back(px);
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10)
            $display("%s", what);
      endfunction

      function void match_pixel(out_pixel_t got);
         out_pixel_t want;
         pixels_seen++;
         if (pixels_due.size() == 0) begin
            flag($sformatf("result %0d arrived with nothing outstanding: rgb %06h %b%b%b",
                           pixels_seen, got.pixel, got.row_end, got.frame_end,
                           got.none_left));
            return;
         end
         want = pixels_due.pop_front();
         if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
             got.frame_end !== want.frame_end || got.none_left !== want.none_left)
            flag($sformatf({"result %0d: expected rgb %06h row_end %b frame_end %b ",
                            "none_left %b, got rgb %06h row_end %b frame_end %b ",
                            "none_left %b"},
                           pixels_seen, want.pixel, want.row_end, want.frame_end,
                           want.none_left, got.pixel, got.row_end, got.frame_end,
                           got.none_left));
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata   = '0;     // in_blue, in_green, in_red
   logic                  req_tuser   = OP_LOAD; // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [PIX_W-1:0]      rsp_tdata;            // out_blue, out_green, out_red
   logic                  rsp_tlast;            // row_end
   logic [1:0]            rsp_tuser;            // frame_end, none_left
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pixel_board  board = new();
   int unsigned burst_left = 0;

   nearest_neighbor_image_scaler_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Register write: setup cycle, then access cycle. Entered at a falling edge.
   task automatic write_reg(input reg_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic apply_cfg(input cfg_type c);
      write_reg(REG_SRC_WIDTH, CSR_DATA_W'(c.src_width));
      write_reg(REG_SRC_HEIGHT, CSR_DATA_W'(c.src_height));
      write_reg(REG_SHRINK, CSR_DATA_W'(c.shrink));
      write_reg(REG_GROW, CSR_DATA_W'(c.grow));
   endtask

   // Offer one beat, idling between bursts of random length.
   task automatic send_beat(input logic op, input logic [PIX_W-1:0] pix);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 16);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = pix;
      do @(posedge clock); while (!req_tready);
      board.take_beat(op, pix);
      burst_left--;
      @(negedge clock);
   endtask

   // Random beat; a read that would reach past the loaded pixels becomes a load.
   task automatic send_random(input int unsigned read_pct);
      logic op;
      op = ($urandom_range(1, 100) <= read_pct) ? OP_READ : OP_LOAD;
      if (op == OP_READ && !board.read_safe())
         op = OP_LOAD;
      send_beat(op, PIX_W'($urandom()));
   endtask

   // Drain all owed pixels, then let the block finish any load in progress.
   task automatic settle();
      req_tvalid = 1'b0;
      while (board.pixels_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [DIM_W-1:0] random_dim();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4)  return '0;
      if (r < 8)  return DIM_W'($urandom_range(DEF_MAX_WIDTH + 1, (1 << DIM_W) - 1));
      if (r < 16) return DIM_W'(DEF_MAX_WIDTH);
      return DIM_W'($urandom_range(1, DEF_MAX_WIDTH));
   endfunction

   // Mostly small factors, so positions stay in a range the run can finish.
   function automatic logic [FAC_W-1:0] random_factor();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4)  return '0;
      if (r < 8)  return FAC_W'($urandom_range(DEF_MAX_FACTOR + 1, (1 << FAC_W) - 1));
      if (r < 14) return FAC_W'(DEF_MAX_FACTOR);
      return FAC_W'($urandom_range(1, 4));
   endfunction

   // Usually a setting that keeps the read position inside the output.
   function automatic cfg_type next_cfg();
      cfg_type     c;
      int unsigned tries;
      tries = ($urandom_range(0, 99) < 15) ? 1 : 20;
      repeat (tries) begin
         c.src_width  = random_dim();
         c.src_height = random_dim();
         c.shrink     = random_factor();
         c.grow       = random_factor();
         if (board.fits(c))
            break;
      end
      return c;
   endfunction

   // Setting with the fewest reads left from the current position to frame end.
   function automatic cfg_type closing_cfg(int unsigned pos_row, int unsigned pos_col);
      cfg_type     best;
      int unsigned best_cost;
      int unsigned w, h, ow, oh, cost;
      best.src_width  = DIM_W'(DEF_MAX_WIDTH);
      best.src_height = DIM_W'(DEF_MAX_HEIGHT);
      best.shrink     = FAC_W'(1);
      best.grow       = FAC_W'(1);
      best_cost       = 32'hFFFF_FFFF;
      for (int unsigned s = 1; s <= DEF_MAX_FACTOR; s++) begin
         for (int unsigned g = 1; g <= DEF_MAX_FACTOR; g++) begin
            w = s * (pos_col / g + 1);
            h = s * (pos_row / g + 1);
            if (w <= DEF_MAX_WIDTH && h <= DEF_MAX_HEIGHT) begin
               ow   = (w / s) * g;
               oh   = (h / s) * g;
               cost = (oh - pos_row - 1) * ow + ow - pos_col;
               if (cost < best_cost) begin
                  best_cost       = cost;
                  best.src_width  = DIM_W'(w);
                  best.src_height = DIM_W'(h);
                  best.shrink     = FAC_W'(s);
                  best.grow       = FAC_W'(g);
               end
            end
         end
      end
      return best;
   endfunction

   // Result side: its own stall pattern, and one long hold-off to back up the block.
   initial begin : result_sink
      int unsigned run_left;
      bit          stalled;
      bit          held;
      out_pixel_t  got;
      run_left = 0;
      stalled  = 1'b0;
      held     = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.pixel     = rsp_tdata;
            got.row_end   = rsp_tlast;
            got.frame_end = rsp_tuser[0];
            got.none_left = rsp_tuser[1];
            board.match_pixel(got);
         end
         @(negedge clock);
         if (!held && board.pixels_seen >= HOLD_AFTER) begin
            held       = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (run_left == 0) begin
            stalled  = !stalled;
            run_left = stalled ? $urandom_range(1, 6)
                     : (($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 12));
         end
         rsp_tready = !stalled;
         run_left--;
      end
   end

   initial begin : stimulus
      int unsigned random_beats;
      int unsigned phase_len;
      int unsigned read_pct;
      int unsigned closing;
      int unsigned trailing;
      random_beats = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Zero width: the load is dropped and the read finds nothing.
      write_reg(REG_SRC_WIDTH, '0);
      send_beat(OP_LOAD, 24'hFF_FFFF);
      send_beat(OP_READ, 24'h00_0000);
      settle();

      // Oversized width with zero height: still an empty frame.
      write_reg(REG_SRC_WIDTH, CSR_DATA_W'((1 << DIM_W) - 1));
      write_reg(REG_SRC_HEIGHT, '0);
      send_beat(OP_LOAD, 24'hA5_A5A5);
      send_beat(OP_READ, 24'hFF_FFFF);
      settle();

      // A 4x2 frame with zero shrink (taken as one) and grow 2: 8x4 output.
      write_reg(REG_SRC_WIDTH, 4);
      write_reg(REG_SRC_HEIGHT, 2);
      write_reg(REG_SHRINK, '0);
      write_reg(REG_GROW, 2);
      send_beat(OP_LOAD, 24'h00_0000);
      send_beat(OP_LOAD, 24'hFF_FFFF);
      send_beat(OP_LOAD, 24'hFF_0000);
      send_beat(OP_LOAD, 24'h00_FF00);
      send_beat(OP_LOAD, 24'h00_00FF);
      send_beat(OP_LOAD, 24'h5A_5A5A);
      send_beat(OP_LOAD, PIX_W'($urandom()));
      send_beat(OP_LOAD, PIX_W'($urandom()));
      // One load past the end of the frame is ignored.
      send_beat(OP_LOAD, 24'hC3_C3C3);
      // A full output row and the first pixel of the next.
      repeat (9) send_beat(OP_READ, PIX_W'($urandom()));
      settle();

      // Oversized grow saturates at the largest factor.
      write_reg(REG_GROW, CSR_DATA_W'((1 << FAC_W) - 1));
      send_beat(OP_READ, 24'h12_3456);
      settle();

      // Zero grow empties the output.
      write_reg(REG_GROW, '0);
      send_beat(OP_READ, 24'h65_4321);
      settle();

      // Oversized shrink leaves nothing of a 4-pixel width.
      write_reg(REG_SHRINK, CSR_DATA_W'((1 << FAC_W) - 1));
      write_reg(REG_GROW, 1);
      send_beat(OP_READ, 24'h0F_0F0F);
      settle();

      // Random phases, each with its own setting and read/load mix.
      while (random_beats < RANDOM_BEATS) begin
         apply_cfg(next_cfg());
         phase_len = $urandom_range(80, 250);
         read_pct  = $urandom_range(30, 80);
         repeat (phase_len) begin
            send_random(read_pct);
            random_beats++;
         end
         settle();
      end

      // Close out the frame, then read a few beats past its end.
      apply_cfg(closing_cfg(board.row, board.col));
      closing  = 0;
      trailing = 0;
      while (trailing < 4 && closing < CLOSING_CAP) begin
         send_random(85);
         closing++;
         if (board.finished)
            trailing++;
      end
      settle();

      if (board.errors == 0)
         $display("nearest_neighbor_image_scaler_top_test: done, clean");
      else
         $display("nearest_neighbor_image_scaler_top_test: done, errors");
      $finish;
   end

   // Watchdog: well beyond the slowest correct run.
   initial begin : watchdog
      #8_000_000;
      $display("nearest_neighbor_image_scaler_top_test: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/nnis_pkg.sv
rtl/nnis_ram.sv
rtl/nnis_div.sv
rtl/nnis_csr.sv
rtl/nearest_neighbor_image_scaler_top.sv
rtl/nnis_checker.sv
verif/nearest_neighbor_image_scaler_top_test.sv
